>>> hdl/mst_pkg.sv
// Package for the multi-slot software timer: sizes, operation and result
// codes, item structs and the control/memory interface structs.
// No dependencies.
`default_nettype none

package mst_pkg;

  localparam int unsigned Slots    = 16;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PeriodW  = 32;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_REGISTER = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_START    = 3'd3,
    OP_STOP     = 3'd4,
    OP_QUERY    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_OK    = 2'd0,
    KIND_ERR   = 2'd1,
    KIND_FIRE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [SlotW-1:0]   slot;
    logic               periodic;
    logic [PeriodW-1:0] period;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SlotW-1:0] result_slot;
    logic             running;
    logic             last;
  } out_item_t;

  // Result handed from the controller to the output register
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_push_t;

  // Slot memory write request; the two arrays never write in the same cycle
  typedef struct packed {
    logic               per_we;
    logic               tim_we;
    logic [SlotW-1:0]   addr;
    logic               periodic;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   deadline;
  } mem_wr_t;

  typedef struct packed {
    logic               rd_en;
    logic [SlotW-1:0]   addr;
  } mem_rd_t;

  typedef struct packed {
    logic               periodic;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   deadline;
  } slot_data_t;

endpackage

`default_nettype wire

>>> hdl/mst_slot_mem.sv
// Slot storage: periodic flag and {period, deadline} per slot in two
// synchronous arrays, registered read. Uses mst_pkg.
`default_nettype none

module mst_slot_mem (
  input  wire logic               clk_i,
  input  wire mst_pkg::mem_wr_t   wr_i,
  input  wire mst_pkg::mem_rd_t   rd_i,
  output mst_pkg::slot_data_t     rd_data_o
);

  logic                                             per_mem [mst_pkg::Slots];
  logic [mst_pkg::PeriodW+mst_pkg::TimeW-1:0]       tim_mem [mst_pkg::Slots];
  logic                                             per_rd_q;
  logic [mst_pkg::PeriodW+mst_pkg::TimeW-1:0]       tim_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.per_we) begin
      per_mem[wr_i.addr] <= wr_i.periodic;
    end
    if (wr_i.tim_we) begin
      tim_mem[wr_i.addr] <= {wr_i.period, wr_i.deadline};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.rd_en) begin
      per_rd_q <= per_mem[rd_i.addr];
      tim_rd_q <= tim_mem[rd_i.addr];
    end
  end

  assign rd_data_o.periodic = per_rd_q;
  assign rd_data_o.period   = tim_rd_q[mst_pkg::PeriodW+mst_pkg::TimeW-1:mst_pkg::TimeW];
  assign rd_data_o.deadline = tim_rd_q[mst_pkg::TimeW-1:0];

endmodule

`default_nettype wire

>>> hdl/mst_ctrl.sv
// Timer controller: registered/enabled flags, time counter, operation
// decode and the tick scan over the slot memory. Uses mst_pkg.
`default_nettype none

module mst_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire mst_pkg::in_item_t   in_item_i,
  output logic                     in_stall_o,
  input  wire logic                out_free_i,
  output mst_pkg::res_push_t       res_o,
  output mst_pkg::mem_wr_t         mem_wr_o,
  output mst_pkg::mem_rd_t         mem_rd_o,
  input  wire mst_pkg::slot_data_t mem_rd_data_i
);

  localparam logic [mst_pkg::SlotW-1:0] LastSlot = mst_pkg::SlotW'(mst_pkg::Slots - 1);

  mst_pkg::state_e               state_q, state_d;
  logic [mst_pkg::Slots-1:0]     reg_q, reg_d;
  logic [mst_pkg::Slots-1:0]     en_q, en_d;
  logic [mst_pkg::TimeW-1:0]     time_q, time_d;
  logic [mst_pkg::SlotW-1:0]     idx_q, idx_d;
  logic                          pend_valid_q, pend_valid_d;
  logic [mst_pkg::SlotW-1:0]     pend_slot_q, pend_slot_d;

  logic accept;
  logic in_reg;
  logic fire;
  logic blocked;

  assign in_stall_o = (state_q != mst_pkg::ST_IDLE) || !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_reg     = reg_q[in_item_i.slot];
  assign fire       = reg_q[idx_q] && en_q[idx_q] && (time_q >= mem_rd_data_i.deadline);
  // a second firing slot must wait until the held one can go out
  assign blocked    = fire && pend_valid_q && !out_free_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mst_pkg::ST_IDLE: begin
        if (accept && (in_item_i.opcode == mst_pkg::OP_TICK)) begin
          state_d = mst_pkg::ST_SCAN;
        end
      end
      mst_pkg::ST_SCAN: begin
        if (!blocked && (idx_q == LastSlot)) begin
          state_d = mst_pkg::ST_FLUSH;
        end
      end
      mst_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free_i) begin
          state_d = mst_pkg::ST_IDLE;
        end
      end
      default: state_d = mst_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    reg_d        = reg_q;
    en_d         = en_q;
    time_d       = time_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    res_o        = '0;
    mem_wr_o     = '0;
    mem_rd_o     = '0;
    mem_rd_o.addr = idx_q;

    case (state_q)
      mst_pkg::ST_IDLE: begin
        if (accept) begin
          res_o.item.result_slot = in_item_i.slot;
          res_o.item.last        = 1'b1;
          res_o.item.kind        = mst_pkg::KIND_OK;
          mem_wr_o.addr          = in_item_i.slot;
          case (in_item_i.opcode)
            mst_pkg::OP_TICK: begin
              time_d        = time_q + mst_pkg::TimeW'(1);
              mem_rd_o.rd_en = 1'b1;
              mem_rd_o.addr  = '0;
              idx_d          = '0;
              pend_valid_d   = 1'b0;
            end
            mst_pkg::OP_REGISTER: begin
              res_o.push = 1'b1;
              if (!in_reg) begin
                reg_d[in_item_i.slot] = 1'b1;
                en_d[in_item_i.slot]  = 1'b0;
                mem_wr_o.per_we       = 1'b1;
                mem_wr_o.periodic     = in_item_i.periodic;
              end
            end
            mst_pkg::OP_REMOVE: begin
              res_o.push = 1'b1;
              if (in_reg) begin
                reg_d[in_item_i.slot] = 1'b0;
              end else begin
                res_o.item.kind = mst_pkg::KIND_ERR;
              end
            end
            mst_pkg::OP_START: begin
              res_o.push = 1'b1;
              if (in_reg && (in_item_i.period != '0)) begin
                en_d[in_item_i.slot] = 1'b1;
                mem_wr_o.tim_we      = 1'b1;
                mem_wr_o.period      = in_item_i.period;
                mem_wr_o.deadline    = time_q + mst_pkg::TimeW'(in_item_i.period);
              end else begin
                res_o.item.kind = mst_pkg::KIND_ERR;
              end
            end
            mst_pkg::OP_STOP: begin
              res_o.push = 1'b1;
              if (in_reg) begin
                en_d[in_item_i.slot] = 1'b0;
              end else begin
                res_o.item.kind = mst_pkg::KIND_ERR;
              end
            end
            mst_pkg::OP_QUERY: begin
              res_o.push         = 1'b1;
              res_o.item.running = in_reg && en_q[in_item_i.slot];
            end
            default: begin
              res_o.push      = 1'b1;
              res_o.item.kind = mst_pkg::KIND_ERR;
            end
          endcase
        end
      end

      mst_pkg::ST_SCAN: begin
        if (!blocked) begin
          if (fire) begin
            // previous fire is now known not to be the final one
            res_o.push             = pend_valid_q;
            res_o.item.kind        = mst_pkg::KIND_FIRE;
            res_o.item.result_slot = pend_slot_q;
            pend_valid_d           = 1'b1;
            pend_slot_d            = idx_q;
            if (mem_rd_data_i.periodic) begin
              mem_wr_o.tim_we   = 1'b1;
              mem_wr_o.addr     = idx_q;
              mem_wr_o.period   = mem_rd_data_i.period;
              mem_wr_o.deadline = mem_rd_data_i.deadline
                                  + mst_pkg::TimeW'(mem_rd_data_i.period);
            end else begin
              en_d[idx_q] = 1'b0;
            end
          end
          if (idx_q != LastSlot) begin
            mem_rd_o.rd_en = 1'b1;
            mem_rd_o.addr  = idx_q + mst_pkg::SlotW'(1);
            idx_d          = idx_q + mst_pkg::SlotW'(1);
          end
        end
      end

      mst_pkg::ST_FLUSH: begin
        if (pend_valid_q && out_free_i) begin
          res_o.push             = 1'b1;
          res_o.item.kind        = mst_pkg::KIND_FIRE;
          res_o.item.result_slot = pend_slot_q;
          res_o.item.last        = 1'b1;
          pend_valid_d           = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mst_pkg::ST_IDLE;
      reg_q        <= '0;
      en_q         <= '0;
      time_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      reg_q        <= reg_d;
      en_q         <= en_d;
      time_q       <= time_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
  end

endmodule

`default_nettype wire

>>> hdl/multi_slot_software_timer.sv
// Multi-slot software timer, top level: controller, slot memory and the
// registered result output. Uses mst_pkg, mst_ctrl, mst_slot_mem.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries operations
//   (tick, register, remove, start, stop, query). Output channel
//   out_valid_o / out_stall_i / out_item_o carries results; an item is
//   taken on a clock edge where valid is high and stall is low.
//   Non-tick operations give one result, registered in the cycle after the
//   item is taken; the next item may be taken in the following cycle.
//   A tick walks the 16 slots through the slot memory, one slot per cycle
//   while a stalled output does not hold the scan, after a first read of
//   slot 0 and before a final flush of the held result. Fire results come
//   out in ascending slot order; each is held one slot behind so the final
//   one can carry last. A tick where nothing fires gives no result.
//   If the receiver stalls, the result stays in the output register and
//   the scan waits on the next firing slot; input stays stalled meanwhile.
//   Reset clears all slot flags, the time counter and the output valid;
//   period and deadline contents are not cleared (written before use).
`default_nettype none

module multi_slot_software_timer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mst_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mst_pkg::out_item_t      out_item_o
);

  mst_pkg::res_push_t   res;
  mst_pkg::mem_wr_t     mem_wr;
  mst_pkg::mem_rd_t     mem_rd;
  mst_pkg::slot_data_t  mem_rd_data;
  mst_pkg::out_item_t   out_q;
  logic                 out_valid_q;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  mst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_item_i     (in_item_i),
    .in_stall_o    (in_stall_o),
    .out_free_i    (out_free),
    .res_o         (res),
    .mem_wr_o      (mem_wr),
    .mem_rd_o      (mem_rd),
    .mem_rd_data_i (mem_rd_data)
  );

  mst_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (mem_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.push) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
